// ----- design/mis_pkg.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// mis_pkg
// shared types and constants for the merge sort inversion counter
// ---------------------------------------------------------------------------
package mis_pkg;

  localparam int DEF_MAX_ITEMS = 32;
  localparam int VALUE_W       = 32;
  localparam int POS_W         = 6;
  localparam int INV_W         = 11;

  typedef struct packed {
    logic signed [VALUE_W-1:0] value;
    logic                      is_last;
  } in_item_t;

  typedef struct packed {
    logic signed [VALUE_W-1:0] sorted_value;
    logic [POS_W-1:0]          position;
    logic [INV_W-1:0]          inversion_total;
    logic                      dropped;
    logic                      last_result;
  } result_t;

  typedef enum logic [2:0] {
    S_LOAD,
    S_SETUP,
    S_READ,
    S_MERGE,
    S_EMIT_RD,
    S_EMIT_OUT
  } state_t;

endpackage

// ----- design/mis_if.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// mis_in_if / mis_out_if
// valid/ready channels for list items and sorted results
// ---------------------------------------------------------------------------
interface mis_in_if import mis_pkg::*; ();
  logic     valid;
  logic     ready;
  in_item_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

interface mis_out_if import mis_pkg::*; ();
  logic    valid;
  logic    ready;
  result_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

// ----- design/mis_ram.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// mis_ram
// element store, one write port and two registered read ports
// ---------------------------------------------------------------------------
module mis_ram import mis_pkg::*; #(
  parameter int DEPTH = DEF_MAX_ITEMS,
  parameter int WIDTH = VALUE_W
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
  output logic [WIDTH-1:0]         rd_data_a,
  output logic [WIDTH-1:0]         rd_data_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data_a <= mem[rd_addr_a];
    rd_data_b <= mem[rd_addr_b];
  end

endmodule

// ----- design/mis_cmp.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// mis_cmp
// merge compare: picks the head of the left or right run, counts split pairs
// ---------------------------------------------------------------------------
module mis_cmp import mis_pkg::*; #(
  parameter int CNT_W = $clog2(DEF_MAX_ITEMS + 1)
) (
  input  logic [CNT_W-1:0]          a,
  input  logic [CNT_W-1:0]          b,
  input  logic [CNT_W-1:0]          mid,
  input  logic [CNT_W-1:0]          hi,
  input  logic signed [VALUE_W-1:0] data_a,
  input  logic signed [VALUE_W-1:0] data_b,
  output logic                      take_a,
  output logic [CNT_W-1:0]          inv_add
);

  logic left_open;
  logic right_open;

  assign left_open  = (a < mid);
  assign right_open = (b < hi);

  // ties go to the left run, which keeps the sort stable
  assign take_a  = left_open && (!right_open || (data_a <= data_b));
  assign inv_add = (left_open && !take_a) ? (mid - a) : '0;

endmodule

// ----- design/merge_sort_inversion_count_top.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// merge_sort_inversion_count_top
// loads a list, merge-sorts it bottom-up and counts inversions, then streams
// the sorted list with the inversion total
//
//   channel   dir   payload                                       beat
//   items     in    value, is_last                                one element
//   results   out   sorted_value, position, inversion_total,      one sorted
//                   dropped, last_result                          element
//
// load: one beat per cycle, no result until the beat marked is_last
// sort: ceil(log2 n) passes over ping-pong stores; each element goes through
//   the shared compare as a registered ram read, then compare and write,
//   after a setup step for each run pair
// emit: a store read, then a wait for out_free; items is not ready from
//   the last beat until the final result is in the output register
// synchronous reset clears control only; the stores need no clearing pass
// ---------------------------------------------------------------------------
module merge_sort_inversion_count_top import mis_pkg::*; #(
  parameter int MAX_ITEMS = DEF_MAX_ITEMS
) (
  input  logic      clk,
  input  logic      rst,
  mis_in_if.sink    items,
  mis_out_if.source results
);

  localparam int IDX_W = $clog2(MAX_ITEMS);
  localparam int CNT_W = $clog2(MAX_ITEMS + 1);
  localparam int SUM_W = CNT_W + 2;

  state_t state;
  state_t state_next;

  logic [CNT_W-1:0] count;
  logic             overflow;
  logic             src_sel;
  logic [CNT_W-1:0] width;
  logic [CNT_W-1:0] lo;
  logic [CNT_W-1:0] mid;
  logic [CNT_W-1:0] hi;
  logic [CNT_W-1:0] a;
  logic [CNT_W-1:0] b;
  logic [CNT_W-1:0] k;
  logic [INV_W-1:0] inv;
  result_t          out_reg;
  logic             out_valid;

  logic             item_beat;
  logic             load_ok;
  logic [CNT_W-1:0] count_after;
  logic             out_free;
  logic             out_load;
  logic             merge_we;
  logic [CNT_W-1:0] k_inc;
  logic [SUM_W-1:0] n_ext;
  logic [SUM_W-1:0] mid_sum;
  logic [SUM_W-1:0] hi_sum;
  logic [SUM_W-1:0] width2;
  logic [CNT_W-1:0] mid_c;
  logic [CNT_W-1:0] hi_c;
  logic             run_done;
  logic             pass_done;
  logic             sort_done;

  logic              take_a;
  logic [CNT_W-1:0]  inv_add;
  logic signed [VALUE_W-1:0] src_a;
  logic signed [VALUE_W-1:0] src_b;
  logic signed [VALUE_W-1:0] merged;

  logic                ram0_we;
  logic                ram1_we;
  logic [IDX_W-1:0]    wr_addr;
  logic [VALUE_W-1:0]  wr_data;
  logic [IDX_W-1:0]    rd_addr_a;
  logic [IDX_W-1:0]    rd_addr_b;
  logic [VALUE_W-1:0]  ram0_a;
  logic [VALUE_W-1:0]  ram0_b;
  logic [VALUE_W-1:0]  ram1_a;
  logic [VALUE_W-1:0]  ram1_b;

  // run bounds and loop tests
  assign item_beat   = items.valid && items.ready;
  assign load_ok     = (count < CNT_W'(MAX_ITEMS));
  assign count_after = load_ok ? (count + CNT_W'(1)) : count;
  assign out_free    = !out_valid || results.ready;
  assign k_inc       = k + CNT_W'(1);
  assign n_ext       = SUM_W'(count);
  assign mid_sum     = SUM_W'(lo) + SUM_W'(width);
  assign width2      = SUM_W'(width) << 1;
  assign hi_sum      = SUM_W'(lo) + width2;
  assign mid_c       = (mid_sum > n_ext) ? count : mid_sum[CNT_W-1:0];
  assign hi_c        = (hi_sum > n_ext) ? count : hi_sum[CNT_W-1:0];
  assign run_done    = (k_inc == hi);
  assign pass_done   = (hi_sum >= n_ext);
  assign sort_done   = (width2 >= n_ext);

  // store access
  assign src_a   = src_sel ? ram1_a : ram0_a;
  assign src_b   = src_sel ? ram1_b : ram0_b;
  assign merged  = take_a ? src_a : src_b;

  assign ram0_we   = (item_beat && load_ok) || (merge_we && src_sel);
  assign ram1_we   = merge_we && !src_sel;
  assign wr_addr   = (state == S_LOAD) ? count[IDX_W-1:0] : k[IDX_W-1:0];
  assign wr_data   = (state == S_LOAD) ? items.payload.value : merged;
  assign rd_addr_a = ((state == S_EMIT_RD) || (state == S_EMIT_OUT)) ?
                     k[IDX_W-1:0] : a[IDX_W-1:0];
  assign rd_addr_b = b[IDX_W-1:0];

  mis_ram #(.DEPTH(MAX_ITEMS), .WIDTH(VALUE_W)) u_ram0 (
    .clk       (clk),
    .wr_en     (ram0_we),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .rd_addr_a (rd_addr_a),
    .rd_addr_b (rd_addr_b),
    .rd_data_a (ram0_a),
    .rd_data_b (ram0_b)
  );

  mis_ram #(.DEPTH(MAX_ITEMS), .WIDTH(VALUE_W)) u_ram1 (
    .clk       (clk),
    .wr_en     (ram1_we),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .rd_addr_a (rd_addr_a),
    .rd_addr_b (rd_addr_b),
    .rd_data_a (ram1_a),
    .rd_data_b (ram1_b)
  );

  mis_cmp #(.CNT_W(CNT_W)) u_cmp (
    .a       (a),
    .b       (b),
    .mid     (mid),
    .hi      (hi),
    .data_a  (src_a),
    .data_b  (src_b),
    .take_a  (take_a),
    .inv_add (inv_add)
  );

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_LOAD;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next  = state;
    items.ready = 1'b0;
    merge_we    = 1'b0;
    out_load    = 1'b0;
    unique case (state)
      S_LOAD: begin
        items.ready = 1'b1;
        if (item_beat && items.payload.is_last) begin
          state_next = (count_after > CNT_W'(1)) ? S_SETUP : S_EMIT_RD;
        end
      end
      S_SETUP: begin
        state_next = S_READ;
      end
      S_READ: begin
        state_next = S_MERGE;
      end
      S_MERGE: begin
        merge_we = 1'b1;
        if (run_done) begin
          state_next = (pass_done && sort_done) ? S_EMIT_RD : S_SETUP;
        end else begin
          state_next = S_READ;
        end
      end
      S_EMIT_RD: begin
        state_next = S_EMIT_OUT;
      end
      S_EMIT_OUT: begin
        if (out_free) begin
          out_load   = 1'b1;
          state_next = (k_inc == count) ? S_LOAD : S_EMIT_RD;
        end
      end
      default: begin
        state_next = S_LOAD;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      overflow  <= 1'b0;
      src_sel   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (item_beat) begin
        count <= count_after;
        if (!load_ok) begin
          overflow <= 1'b1;
        end
      end
      if (merge_we && run_done && pass_done) begin
        src_sel <= ~src_sel;
      end
      if (out_load && (k_inc == count)) begin
        count    <= '0;
        overflow <= 1'b0;
        src_sel  <= 1'b0;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (results.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // sort and emit datapath
  always_ff @(posedge clk) begin
    unique case (state)
      S_LOAD: begin
        if (item_beat && items.payload.is_last) begin
          width <= CNT_W'(1);
          lo    <= '0;
          k     <= '0;
          inv   <= '0;
        end
      end
      S_SETUP: begin
        mid <= mid_c;
        hi  <= hi_c;
        a   <= lo;
        b   <= mid_c;
        k   <= lo;
      end
      S_READ: begin
      end
      S_MERGE: begin
        inv <= inv + INV_W'(inv_add);
        if (take_a) begin
          a <= a + CNT_W'(1);
        end else begin
          b <= b + CNT_W'(1);
        end
        if (run_done) begin
          if (pass_done) begin
            lo    <= '0;
            width <= width2[CNT_W-1:0];
            k     <= '0;
          end else begin
            lo <= hi_sum[CNT_W-1:0];
            k  <= k_inc;
          end
        end else begin
          k <= k_inc;
        end
      end
      S_EMIT_RD: begin
      end
      S_EMIT_OUT: begin
        if (out_free) begin
          out_reg.sorted_value    <= src_a;
          out_reg.position        <= POS_W'(k);
          out_reg.inversion_total <= inv;
          out_reg.dropped         <= overflow;
          out_reg.last_result     <= (k_inc == count);
          k                       <= k_inc;
        end
      end
      default: begin
      end
    endcase
  end

  assign results.valid   = out_valid;
  assign results.payload = out_reg;

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(MAX_ITEMS))
    else $error("element count above capacity");

  a_merge_source: assert property (@(posedge clk) disable iff (rst)
    (state == S_MERGE) |-> ((a < mid) || (b < hi)))
    else $error("merge step with both runs exhausted");

  a_emit_clears: assert property (@(posedge clk) disable iff (rst)
    (out_load && (k_inc == count)) |=> ((count == '0) && !overflow && (state == S_LOAD)))
    else $error("list state not cleared after final result");

endmodule

// ----- verif/mis_sort_checker.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// mis_sort_checker
// watches the item and result channels of the merge sort inversion counter,
// keeps its own copy of the loaded list, predicts the sorted list with its
// inversion total and drop flag, and compares every result beat against the
// oldest prediction
// ---------------------------------------------------------------------------
module mis_sort_checker import mis_pkg::*; #(
  parameter int MAX_ITEMS = DEF_MAX_ITEMS
) (
  input  logic        clk,
  input  logic        rst,
  mis_in_if           items,
  mis_out_if          results,
  output int unsigned mismatch_count,
  output int unsigned results_owed
);

  logic signed [VALUE_W-1:0] held_vals[$];
  logic                      overflow_hit;
  result_t                   sorted_expect_q[$];

  task automatic note_failure(input string msg);
    mismatch_count++;
    if (mismatch_count <= 10) $display("%0t: %s", $time, msg);
  endtask

  // stable insertion sort plus a direct pair count
  function automatic void predict_sorted_list();
    logic signed [VALUE_W-1:0] vals[$];
    logic signed [VALUE_W-1:0] key;
    int unsigned               inv;
    int                        j;
    result_t                   r;
    vals = held_vals;
    inv  = 0;
    for (int a = 0; a < vals.size(); a++) begin
      for (int b = a + 1; b < vals.size(); b++) begin
        if (vals[a] > vals[b]) inv++;
      end
    end
    for (int i = 1; i < vals.size(); i++) begin
      key = vals[i];
      j   = i - 1;
      while (j >= 0 && vals[j] > key) begin
        vals[j+1] = vals[j];
        j--;
      end
      vals[j+1] = key;
    end
    for (int k = 0; k < vals.size(); k++) begin
      r.sorted_value    = vals[k];
      r.position        = k[POS_W-1:0];
      r.inversion_total = inv[INV_W-1:0];
      r.dropped         = overflow_hit;
      r.last_result     = (k == vals.size() - 1);
      sorted_expect_q.push_back(r);
    end
  endfunction

  task automatic take_item(input in_item_t it);
    if (held_vals.size() < MAX_ITEMS) held_vals.push_back(it.value);
    else overflow_hit = 1'b1;
    if (it.is_last) begin
      predict_sorted_list();
      held_vals.delete();
      overflow_hit = 1'b0;
    end
  endtask

  task automatic check_result(input result_t got);
    result_t want;
    if (sorted_expect_q.size() == 0) begin
      note_failure($sformatf("unexpected result beat: value %0d pos %0d inv %0d drop %0b last %0b",
        got.sorted_value, got.position, got.inversion_total, got.dropped, got.last_result));
    end else begin
      want = sorted_expect_q.pop_front();
      if (got.sorted_value !== want.sorted_value || got.position !== want.position ||
          got.inversion_total !== want.inversion_total || got.dropped !== want.dropped ||
          got.last_result !== want.last_result) begin
        note_failure($sformatf({"result mismatch: exp value %0d pos %0d inv %0d drop %0b ",
          "last %0b / got value %0d pos %0d inv %0d drop %0b last %0b"},
          want.sorted_value, want.position, want.inversion_total, want.dropped,
          want.last_result, got.sorted_value, got.position, got.inversion_total,
          got.dropped, got.last_result));
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      held_vals.delete();
      overflow_hit = 1'b0;
      sorted_expect_q.delete();
    end else begin
      if (results.valid === 1'b1 && results.ready === 1'b1) check_result(results.payload);
      if (items.valid === 1'b1 && items.ready === 1'b1) take_item(items.payload);
    end
    results_owed = sorted_expect_q.size();
  end

endmodule

// ----- verif/tb_top.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_top
// drives lists into the merge sort inversion counter: a short directed set
// (extreme values, ties, single element) then random lists of mixed length,
// including a full list with the most inversions and lists past capacity,
// across phases of sender gaps and receiver stalls; the checker beside the
// block predicts and compares, this module gives the verdict
// ---------------------------------------------------------------------------
module tb_top;
  import mis_pkg::*;

  localparam int MAX_ITEMS   = DEF_MAX_ITEMS;
  localparam int CYCLE_LIMIT = 300000;
  localparam int PHASE_ITEMS = 16;

  localparam logic signed [VALUE_W-1:0] VAL_MIN = {1'b1, {(VALUE_W-1){1'b0}}};
  localparam logic signed [VALUE_W-1:0] VAL_MAX = {1'b0, {(VALUE_W-1){1'b1}}};

  logic        clk;
  logic        rst;
  int unsigned mismatch_count;
  int unsigned results_owed;
  int          send_idle_pct;
  int          stall_pct;

  mis_in_if  items ();
  mis_out_if results ();

  merge_sort_inversion_count_top #(.MAX_ITEMS(MAX_ITEMS)) dut (
    .clk     (clk),
    .rst     (rst),
    .items   (items),
    .results (results)
  );

  mis_sort_checker #(.MAX_ITEMS(MAX_ITEMS)) chk (
    .clk            (clk),
    .rst            (rst),
    .items          (items),
    .results        (results),
    .mismatch_count (mismatch_count),
    .results_owed   (results_owed)
  );

  initial clk = 1'b0;
  always #4 clk = ~clk;

  // receiver side
  initial begin
    results.ready = 1'b0;
    forever begin
      @(negedge clk);
      results.ready = ($urandom_range(0, 99) >= stall_pct);
    end
  end

  initial begin : watchdog
    int unsigned cycle_cnt;
    cycle_cnt = 0;
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("*** FAILED ***");
    $finish;
  end

  task automatic send_beat(input logic signed [VALUE_W-1:0] v, input logic last);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      items.valid = 1'b0;
      @(negedge clk);
    end
    items.valid           = 1'b1;
    items.payload.value   = v;
    items.payload.is_last = last;
    @(posedge clk);
    while (items.ready !== 1'b1) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic send_list(input logic signed [VALUE_W-1:0] vals[$], inout int sent);
    for (int i = 0; i < vals.size(); i++) begin
      send_beat(vals[i], i == vals.size() - 1);
      sent++;
    end
  endtask

  function automatic logic signed [VALUE_W-1:0] pick_value(input int mode);
    logic signed [VALUE_W-1:0] v;
    case ($urandom_range(0, 4))
      0:       v = VAL_MIN;
      1:       v = VAL_MAX;
      2:       v = '0;
      3:       v = '1;
      default: v = 1;
    endcase
    if (mode == 0) v = $urandom;
    else if (mode == 1) v = $signed($urandom_range(0, 6)) - 3;
    return v;
  endfunction

  task automatic send_random_list(input int len, inout int sent);
    logic signed [VALUE_W-1:0] vals[$];
    int                        mode;
    mode = $urandom_range(0, 2);
    for (int i = 0; i < len; i++) vals.push_back(pick_value(mode));
    send_list(vals, sent);
  endtask

  initial begin
    logic signed [VALUE_W-1:0] q[$];
    int                        sent;
    int                        len;
    int                        pick;
    rst                   = 1'b1;
    items.valid           = 1'b0;
    items.payload         = '0;
    send_idle_pct         = 0;
    stall_pct             = 0;
    sent                  = 0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // single elements at both extremes
    q = {VAL_MIN};
    send_list(q, sent);
    q = {VAL_MAX};
    send_list(q, sent);
    // extremes mixed, ties, reversed run
    q = {VAL_MAX, VAL_MIN, 32'sd0, -32'sd1, 32'sd1, VAL_MIN};
    send_list(q, sent);
    q = {32'sd7, -32'sd3, 32'sd7, -32'sd3, 32'sd7};
    send_list(q, sent);
    q = {32'sd4, 32'sd3, 32'sd2, 32'sd1};
    send_list(q, sent);

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0:       begin send_idle_pct = 0;  stall_pct = 0;  end
        1:       begin send_idle_pct = 75; stall_pct = 0;  end
        2:       begin send_idle_pct = 0;  stall_pct = 75; end
        default: begin send_idle_pct = 11; stall_pct = 11; end
      endcase
      sent = 0;
      if (ph == 1) begin
        // full store in strictly falling order: most inversions
        q.delete();
        for (int k = 0; k < MAX_ITEMS; k++) q.push_back(32'sd1000 - 7 * k);
        send_list(q, sent);
      end else if (ph == 2) begin
        // past capacity, marked beat dropped too
        send_random_list(MAX_ITEMS + 5, sent);
      end
      while (sent < PHASE_ITEMS) begin
        pick = $urandom_range(0, 9);
        if (pick < 7) len = $urandom_range(1, 6);
        else if (pick < 9) len = $urandom_range(7, 16);
        else len = $urandom_range(MAX_ITEMS - 2, MAX_ITEMS + 4);
        send_random_list(len, sent);
      end
    end
    items.valid = 1'b0;

    while (results_owed != 0) @(negedge clk);
    repeat (40) @(negedge clk);
    if (mismatch_count == 0 && results_owed == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end

endmodule

// ----- sim.f -----
design/mis_pkg.sv
design/mis_if.sv
design/mis_ram.sv
design/mis_cmp.sv
design/merge_sort_inversion_count_top.sv
verif/mis_sort_checker.sv
verif/tb_top.sv
